FILE: sv/mvp_pkg.sv
// Shared types and constants for the max-visible-points block.
// No dependencies; imported by every module of the block.
package mvp_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int VIEW_W       = 9;
  localparam logic [VIEW_W-1:0] VIEW_RESET = 9'd90;
  localparam logic [VIEW_W:0]   DEG_TURN   = 10'd360;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D
  };

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } mvp_in_t;

  typedef struct packed {
    logic [10:0] max_visible;
    logic        overflowed;
  } mvp_out_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;
    logic ins_en;
    logic scan_load;
    logic scan_en;
    logic drain_en;
  } cell_ctrl_t;

endpackage

FILE: sv/mvp_cordic.sv
// Iterative vectoring CORDIC: polar angle of a point as a fraction of a turn.
// Depends on mvp_pkg (arctangent table).
module mvp_cordic import mvp_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [15:0]    x_in,
  input  logic signed [15:0]    y_in,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] angle
);
  localparam int SH = 32 - ANGLE_BITS;
  localparam logic [31:0] RND = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, x0, y0;
  logic [31:0] z_r, z_nxt, z_rnd;
  logic [3:0]  it_r, it_nxt;
  logic        run_r, run_nxt, org_r, org_nxt, done_r, done_nxt;
  logic signed [33:0] xs, ys;

  assign x0 = 34'(x_in) <<< 14;
  assign y0 = 34'(y_in) <<< 14;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  // one micro-rotation per cycle
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    run_nxt = run_r; org_nxt = org_r; done_nxt = 1'b0;
    if (start) begin
      org_nxt = (x_in == 16'sd0) && (y_in == 16'sd0);
      run_nxt = 1'b1;
      it_nxt  = '0;
      if (x_in < 16'sd0) begin
        x_nxt = -x0; y_nxt = -y0; z_nxt = 32'h80000000;
      end else begin
        x_nxt = x0; y_nxt = y0; z_nxt = '0;
      end
    end else if (run_r) begin
      if (y_r > 34'sd0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + ATAN_TURN[it_r];
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - ATAN_TURN[it_r];
      end
      it_nxt = it_r + 4'd1;
      if (it_r == 4'(CORDIC_ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt; org_r <= org_nxt;
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt;
    end
  end

  // round to the output width; origin forced to zero
  assign z_rnd = z_r + RND;
  assign done  = done_r;
  assign angle = org_r ? '0 : z_rnd[31 -: ANGLE_BITS];

endmodule

FILE: sv/mvp_cell.sv
// One cell of the sorted angle chain: holds an angle, counts window hits
// against a circulating probe, then shifts its count out. Uses mvp_pkg.
module mvp_cell import mvp_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int CW         = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [ANGLE_BITS-1:0] ins_angle,
  input  logic [ANGLE_BITS+8:0] width,
  input  logic [ANGLE_BITS-1:0] left_angle,
  input  logic                  left_valid,
  input  logic                  left_gt,
  input  logic [ANGLE_BITS-1:0] probe_in,
  input  logic                  probe_v_in,
  input  logic [CW-1:0]         cnt_in,
  output logic [ANGLE_BITS-1:0] angle_o,
  output logic                  valid_o,
  output logic                  gt_o,
  output logic [ANGLE_BITS-1:0] probe_o,
  output logic                  probe_v_o,
  output logic [CW-1:0]         cnt_o
);
  logic [ANGLE_BITS-1:0] angle_r, angle_nxt, probe_r, probe_nxt, diff;
  logic                  valid_r, valid_nxt, probe_v_r, probe_v_nxt, gt, hit;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  assign gt   = valid_r && (angle_r > ins_angle);
  assign diff = probe_r - angle_r;
  assign hit  = valid_r && probe_v_r && ({9'd0, diff} <= width);

  // sorted insert: shift right where the neighbor is larger, else take new
  always_comb begin
    angle_nxt = angle_r; valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins_en) begin
      if (left_gt) begin
        angle_nxt = left_angle; valid_nxt = 1'b1;
      end else if (gt || (!valid_r && left_valid)) begin
        angle_nxt = ins_angle; valid_nxt = 1'b1;
      end
    end
  end

  // probe ring and hit counter / count drain
  always_comb begin
    probe_nxt = probe_r; probe_v_nxt = probe_v_r; cnt_nxt = cnt_r;
    if (ctrl.scan_load) begin
      probe_nxt = angle_r; probe_v_nxt = valid_r; cnt_nxt = '0;
    end else if (ctrl.scan_en) begin
      probe_nxt = probe_in; probe_v_nxt = probe_v_in;
      if (hit) cnt_nxt = cnt_r + CW'(1);
    end else if (ctrl.drain_en) begin
      cnt_nxt = cnt_in;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt; probe_r <= probe_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0; probe_v_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt; probe_v_r <= probe_v_nxt;
    end
  end

  assign angle_o   = angle_r;
  assign valid_o   = valid_r;
  assign gt_o      = gt;
  assign probe_o   = probe_r;
  assign probe_v_o = probe_v_r;
  assign cnt_o     = cnt_r;

endmodule

FILE: sv/max_visible_points_in_view_angle.sv
// Top level: CORDIC angle unit, sorted chain of cells, window scan control.
// Per point: 16 CORDIC steps, angle handoff, insert, and the idle state that
// accepts the next point; the CORDIC sets the pace.
// Last point: after its insert, the strobe follows the width, load, scan and drain states.
// One point at a time; busy is high while a transaction is in flight; no output stall.
// Synchronous active-low reset: empty store, view 90 degrees, stored-point count and result zero.
module max_visible_points_in_view_angle import mvp_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mvp_in_t           in_data,
  output logic              out_valid,
  output mvp_out_t          out_data,
  input  logic              cfg_we,
  input  logic [VIEW_W-1:0] cfg_wdata
);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = ANGLE_BITS + VIEW_W;
  // width = view*(TURN/360) + floor(view*(TURN%360)/360), the second by reciprocal
  localparam longint TURN = longint'(1) << ANGLE_BITS;
  localparam int WQ   = int'(TURN / DEG_TURN);
  localparam int WR   = int'(TURN % DEG_TURN);
  localparam int RSH  = 28;
  localparam int RMUL = int'(((longint'(1) << RSH) + longint'(DEG_TURN) - 1) / DEG_TURN);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_INS   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [VIEW_W-1:0]     view_r;
  logic                  last_r, last_nxt;
  logic [ANGLE_BITS-1:0] ang_r, ang_nxt;
  logic [CW-1:0]         sc_r, sc_nxt, best_r, best_nxt, max_r, max_nxt, tmr_r, tmr_nxt;
  logic                  drop_r, drop_nxt, emit_r, emit_nxt;
  logic [DW-1:0]         q_r, q_nxt;
  logic [DW-1:0]         wid_base;
  logic [VIEW_W+8:0]     wid_rp;
  logic [VIEW_W+28:0]    wid_rq;
  logic                  cord_done;
  logic [ANGLE_BITS-1:0] cord_angle;
  cell_ctrl_t            ctrl;
  logic [CW+10:0]        best_ext;

  logic [ANGLE_BITS-1:0] c_ang [MAX_POINTS];
  logic [ANGLE_BITS-1:0] c_prb [MAX_POINTS];
  logic [CW-1:0]         c_cnt [MAX_POINTS];
  logic                  c_val [MAX_POINTS];
  logic                  c_gt  [MAX_POINTS];
  logic                  c_pv  [MAX_POINTS];

  assign busy = (state_r != S_IDLE);

  mvp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(start && !busy),
    .x_in(in_data.point_x), .y_in(in_data.point_y),
    .done(cord_done), .angle(cord_angle)
  );

  // chain of cells; cell 0 sees an always-valid, never-larger left edge
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic [ANGLE_BITS-1:0] la, lp;
    logic                  lv, lg, lpv;
    logic [CW-1:0]         lc;
    if (k == 0) begin : g_head
      assign la = '0; assign lv = 1'b1; assign lg = 1'b0; assign lc = '0;
      assign lp = c_prb[MAX_POINTS-1]; assign lpv = c_pv[MAX_POINTS-1];
    end else begin : g_body
      assign la = c_ang[k-1]; assign lv = c_val[k-1]; assign lg = c_gt[k-1];
      assign lc = c_cnt[k-1]; assign lp = c_prb[k-1]; assign lpv = c_pv[k-1];
    end
    mvp_cell #(.ANGLE_BITS(ANGLE_BITS), .CW(CW)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .ins_angle(ang_r), .width(q_r),
      .left_angle(la), .left_valid(lv), .left_gt(lg),
      .probe_in(lp), .probe_v_in(lpv), .cnt_in(lc),
      .angle_o(c_ang[k]), .valid_o(c_val[k]), .gt_o(c_gt[k]),
      .probe_o(c_prb[k]), .probe_v_o(c_pv[k]), .cnt_o(c_cnt[k])
    );
  end

  // window width floor(view*2^ANGLE_BITS/360); reciprocal is exact for 9-bit views
  assign wid_base = DW'(view_r) * DW'(WQ);
  assign wid_rp   = (VIEW_W+9)'(view_r) * (VIEW_W+9)'(WR);
  assign wid_rq   = (VIEW_W+29)'(wid_rp) * (VIEW_W+29)'(RMUL);

  // sequencer
  always_comb begin
    state_nxt = state_r; last_nxt = last_r; ang_nxt = ang_r; sc_nxt = sc_r;
    best_nxt = best_r; max_nxt = max_r; tmr_nxt = tmr_r; drop_nxt = drop_r;
    emit_nxt = 1'b0; q_nxt = q_r;
    ctrl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt  = in_data.last_point;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        if (cord_done) begin
          ang_nxt   = cord_angle;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (sc_r == CW'(MAX_POINTS)) begin
          drop_nxt = 1'b1;
        end else begin
          ctrl.ins_en = 1'b1;
          sc_nxt = sc_r + CW'(1);
        end
        if (last_r) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        q_nxt = wid_base + DW'(wid_rq[VIEW_W+28:RSH]);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ctrl.scan_load = 1'b1;
        tmr_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctrl.scan_en = 1'b1;
        tmr_nxt = tmr_r + CW'(1);
        if (tmr_r == CW'(MAX_POINTS - 1)) begin
          tmr_nxt = '0; max_nxt = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctrl.drain_en = 1'b1;
        if (c_cnt[MAX_POINTS-1] > max_r) max_nxt = c_cnt[MAX_POINTS-1];
        tmr_nxt = tmr_r + CW'(1);
        if (tmr_r == CW'(MAX_POINTS - 1)) begin
          best_nxt = (c_cnt[MAX_POINTS-1] > max_r) ? c_cnt[MAX_POINTS-1] : max_r;
          emit_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // end of set: empty the store for the next one
    if (emit_r) begin
      ctrl.clear = 1'b1;
      sc_nxt = '0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt; ang_r <= ang_nxt; max_r <= max_nxt; tmr_r <= tmr_nxt;
    q_r <= q_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE; view_r <= VIEW_RESET; sc_r <= '0; best_r <= '0;
      drop_r <= 1'b0; emit_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sc_r <= sc_nxt; best_r <= best_nxt;
      drop_r <= drop_nxt; emit_r <= emit_nxt;
      if (cfg_we) view_r <= cfg_wdata;
    end
  end

  // result transaction: strobe for one cycle
  assign best_ext             = {11'd0, best_r};
  assign out_valid            = emit_r;
  assign out_data.max_visible = best_ext[10:0];
  assign out_data.overflowed  = drop_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DRAIN)) else $error("result without drain");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= CW'(MAX_POINTS)) else $error("stored count beyond capacity");

endmodule
